// ===== sv/urr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the round-robin ultrasonic ranger.
// No dependencies; every other file of the block imports this package.
package urr_pkg;

    // Event kinds on the input channel.
    localparam logic FUNC_POLL = 1'b0;
    localparam logic FUNC_ECHO = 1'b1;

    // Result kinds on the output channel.
    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_TRIGGER = 1'b1;

    // Reach of the 4-bit sensor index.
    localparam int INDEX_REACH = 16;

    // Distance conversion: 29 us per cm each way, so 58 us per cm of range.
    localparam int          SOUND_US_PER_CM = 29;
    localparam int          ROUND_TRIP      = 2;
    localparam logic [7:0]  UNKNOWN_CM      = 8'd199;
    // Elapsed times at or above this value saturate to the unknown distance.
    localparam logic [31:0] SAT_US = 32'((UNKNOWN_CM + 1) * SOUND_US_PER_CM * ROUND_TRIP);
    // floor(x / 29) = (x * RECIP_29) >> RECIP_SHIFT for every x below SAT_US / 2.
    localparam logic [15:0] RECIP_29    = 16'd36158;
    localparam int          RECIP_SHIFT = 20;
    localparam int          HALF_W      = 13;

    // Entries in the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Input item.
    typedef struct packed {
        logic        func;
        logic        echo_level;
        logic [31:0] time_us;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic       kind;
        logic [3:0] sensor_index;
        logic [7:0] distance_cm;
        logic       last;
    } out_item_t;

    // Work handed from the front to the back.
    typedef enum logic [1:0] {
        CMD_TRIGGER,
        CMD_MISS_TRIGGER,
        CMD_REPORT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic [3:0]          prev_sensor;
        logic [3:0]          sensor;
        logic                sat;
        logic [HALF_W-1:0]   half_elapsed;
    } cmd_t;

endpackage

// ===== sv/urr_front.sv =====
`timescale 1ns / 1ps
// Front end of the ranger: accepts events, keeps the rotation and echo state,
// and turns each event into a queued command. Depends on urr_pkg.
module urr_front #(
    parameter int SENSOR_SLOTS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [4:0]       cfg_wdata,
    input  logic             in_valid,
    output logic             in_stall,
    input  urr_pkg::in_item_t in_item,
    output logic             push_valid,
    output urr_pkg::cmd_t    push_cmd,
    input  logic             queue_full
);
    import urr_pkg::*;

    // Number of sensors the rotation can reach at all.
    localparam logic [4:0] CAP = (SENSOR_SLOTS < INDEX_REACH) ? 5'(SENSOR_SLOTS)
                                                              : 5'(INDEX_REACH);

    logic [4:0]  sensor_count_reg;
    logic [3:0]  active_reg, active_next;
    logic        pending_reg, pending_next;
    logic [31:0] start_reg, start_next;

    logic        accept;
    logic [4:0]  eff_count;
    logic [4:0]  inc;
    logic [3:0]  rotated;
    logic [31:0] elapsed;

    // An event is taken whenever the queue has room.
    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    // Enabled sensors, limited to the reachable range.
    assign eff_count = (sensor_count_reg > CAP) ? CAP : sensor_count_reg;

    // Next sensor in the rotation, wrapping at the enabled count.
    assign inc     = {1'b0, active_reg} + 5'd1;
    assign rotated = (inc >= eff_count) ? 4'd0 : inc[3:0];

    // Modular echo duration.
    assign elapsed = in_item.time_us - start_reg;

    // Classify the event and update the measurement state.
    always_comb
    begin
        active_next  = active_reg;
        pending_next = pending_reg;
        start_next   = start_reg;
        push_valid   = 1'b0;
        push_cmd.op           = CMD_REPORT;
        push_cmd.prev_sensor  = active_reg;
        push_cmd.sensor       = active_reg;
        push_cmd.sat          = (elapsed >= SAT_US);
        push_cmd.half_elapsed = elapsed[HALF_W:1];
        if (accept)
        begin
            if (in_item.func == FUNC_POLL)
            begin
                if (eff_count != 5'd0)
                begin
                    active_next     = rotated;
                    pending_next    = 1'b1;
                    push_valid      = 1'b1;
                    push_cmd.op     = pending_reg ? CMD_MISS_TRIGGER : CMD_TRIGGER;
                    push_cmd.sensor = rotated;
                end
            end
            else if (in_item.echo_level)
            begin
                pending_next = 1'b1;
                start_next   = in_item.time_us;
            end
            else
            begin
                pending_next = 1'b0;
                push_valid   = 1'b1;
            end
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_count_reg <= 5'd0;
        end
        else if (cfg_we)
        begin
            sensor_count_reg <= cfg_wdata;
        end
    end

    // Measurement state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 4'd0;
            pending_reg <= 1'b0;
            start_reg   <= 32'd0;
        end
        else
        begin
            active_reg  <= active_next;
            pending_reg <= pending_next;
            start_reg   <= start_next;
        end
    end

    // A sensor chosen by a poll tick is always inside the enabled range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_cmd.op != CMD_REPORT) |-> ({1'b0, push_cmd.sensor} < eff_count))
        else $error("Rotation picked a sensor outside the enabled range.");

    // A poll tick with sensors enabled leaves the echo pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_item.func == FUNC_POLL) && (eff_count != 5'd0)) |=> pending_reg)
        else $error("Poll tick did not mark the echo pending.");

    // A falling echo edge clears the pending flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_item.func == FUNC_ECHO) && !in_item.echo_level) |=> !pending_reg)
        else $error("Falling echo edge did not clear the pending flag.");

endmodule

// ===== sv/urr_queue.sv =====
`timescale 1ns / 1ps
// Short command queue that decouples the front from the back.
// Depends on urr_pkg for the command type and depth.
module urr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    input  urr_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output urr_pkg::cmd_t head_cmd
);
    import urr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    assign do_push = push_valid && !full;
    assign do_pop  = pop && head_valid;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // The fill count never passes the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("Command queue overfilled.");

    // Pointers meet whenever the queue is empty or full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("Queue pointers disagree with the fill count.");

    // The front never offers a command to a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> !full)
        else $error("Command pushed into a full queue.");

endmodule

// ===== sv/urr_back.sv =====
`timescale 1ns / 1ps
// Back end of the ranger: executes queued commands, converts echo time to
// centimeters and holds the output register. Depends on urr_pkg.
module urr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  urr_pkg::cmd_t      head_cmd,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output urr_pkg::out_item_t out_item
);
    import urr_pkg::*;

    localparam int PROD_W = HALF_W + 16;

    out_item_t          out_reg, out_next;
    logic               out_valid_reg, out_valid_next;
    logic               phase_reg, phase_next;
    logic               load;
    logic [PROD_W-1:0]  product;
    logic [7:0]         quotient;

    // Divide the half duration by 29 through the reciprocal.
    assign product  = PROD_W'(head_cmd.half_elapsed) * PROD_W'(RECIP_29);
    assign quotient = product[RECIP_SHIFT+7:RECIP_SHIFT];

    // The output register takes a new result when empty or being drained.
    assign load = !out_valid_reg || !out_stall;

    // Build the next result; a miss-then-trigger command takes two transfers.
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        phase_next     = phase_reg;
        pop            = 1'b0;
        if (load && head_valid)
        begin
            out_valid_next = 1'b1;
            case (head_cmd.op)
                CMD_MISS_TRIGGER:
                begin
                    if (!phase_reg)
                    begin
                        out_next.kind         = KIND_REPORT;
                        out_next.sensor_index = head_cmd.prev_sensor;
                        out_next.distance_cm  = UNKNOWN_CM;
                        out_next.last         = 1'b0;
                        phase_next            = 1'b1;
                    end
                    else
                    begin
                        out_next.kind         = KIND_TRIGGER;
                        out_next.sensor_index = head_cmd.sensor;
                        out_next.distance_cm  = 8'd0;
                        out_next.last         = 1'b1;
                        phase_next            = 1'b0;
                        pop                   = 1'b1;
                    end
                end
                CMD_TRIGGER:
                begin
                    out_next.kind         = KIND_TRIGGER;
                    out_next.sensor_index = head_cmd.sensor;
                    out_next.distance_cm  = 8'd0;
                    out_next.last         = 1'b1;
                    pop                   = 1'b1;
                end
                default:
                begin
                    out_next.kind         = KIND_REPORT;
                    out_next.sensor_index = head_cmd.sensor;
                    out_next.distance_cm  = head_cmd.sat ? UNKNOWN_CM : quotient;
                    out_next.last         = 1'b1;
                    pop                   = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // The second half of a split command is still at the queue head.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (head_valid && head_cmd.op == CMD_MISS_TRIGGER))
        else $error("Split command lost from the queue head.");

    // Only the unknown report of a missed echo is not the last result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.last) |->
            (out_item.kind == KIND_REPORT && out_item.distance_cm == UNKNOWN_CM))
        else $error("Non-final result is not an unknown report.");

    // A missed-echo report is followed by its trigger in the next transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !out_item.last) |=>
            (out_valid && out_item.kind == KIND_TRIGGER))
        else $error("Trigger did not follow the missed-echo report.");

endmodule

// ===== sv/ultrasonic_round_robin_ranger.sv =====
`timescale 1ns / 1ps
// Top level of the round-robin ultrasonic ranger: front, command queue, back.
// Depends on urr_pkg, urr_front, urr_queue and urr_back.
//
//   Channel   Handshake                Payload      Direction
//   in        in_valid / in_stall      in_item      into block
//   out       out_valid / out_stall    out_item     out of block
//   cfg       cfg_we                   cfg_wdata    into block
//
// One event is accepted per cycle while the four-entry command queue has room.
// A result passes through the command queue and then the output register; a poll tick
// that finds its echo still pending gives two results, so the output side sustains one
// transfer per cycle while out_stall is low, and the queue soaks up the extra.
// Reset is asynchronous and active low and clears the rotation, echo state and
// sensor count. A stall on the output holds the output register; the queue then
// fills and in_stall rises once it is full.
module ultrasonic_round_robin_ranger #(
    parameter int SENSOR_SLOTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  urr_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output urr_pkg::out_item_t out_item
);
    import urr_pkg::*;

    logic  push_valid;
    cmd_t  push_cmd;
    logic  queue_full;
    logic  pop;
    logic  head_valid;
    cmd_t  head_cmd;

    // Event classification and measurement state.
    urr_front #(
        .SENSOR_SLOTS (SENSOR_SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    // Decoupling queue.
    urr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Result generation.
    urr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule

// ===== tb/sv/ultrasonic_round_robin_ranger_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the round-robin ultrasonic ranger: directed and random events.
// Depends on urr_pkg and ultrasonic_round_robin_ranger; results are checked in order
// against an in-bench predictor of the rotation, echo timing and distance math.
module ultrasonic_round_robin_ranger_tb;

    import urr_pkg::*;

    localparam int          SLOTS         = 16;
    localparam logic        ECHO_RISE     = 1'b1;
    localparam logic        ECHO_FALL     = 1'b0;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          END_CYCLES    = 32;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          PHASE_EVENTS  = 190;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    logic [4:0] cfg_wdata = '0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;

    // Predictor state and configuration.
    logic [4:0]  m_count   = '0;
    logic [3:0]  m_active  = '0;
    logic        m_waiting = 1'b0;
    logic [31:0] m_echo_t0 = '0;

    // Results still owed by the block, oldest first.
    out_item_t awaited_results[$];
    out_item_t want;

    int unsigned idle_pct        = 0;
    int unsigned stall_pct       = 0;
    int unsigned events_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches      = 0;
    int unsigned cycle_count     = 0;
    logic [31:0] clock_us        = '0;

    ultrasonic_round_robin_ranger #(
        .SENSOR_SLOTS(SLOTS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Number of sensors actually in the rotation.
    function automatic int unsigned sensors_in_use();
        int unsigned limit;
        limit = 32'(m_count);
        if (limit > SLOTS)
            limit = SLOTS;
        if (limit > INDEX_REACH)
            limit = INDEX_REACH;
        return limit;
    endfunction

    function automatic out_item_t make_result(logic kind, logic [3:0] sensor,
                                              logic [7:0] dist_cm, logic last);
        out_item_t r;
        r.kind         = kind;
        r.sensor_index = sensor;
        r.distance_cm  = dist_cm;
        r.last         = last;
        return r;
    endfunction

    // Advance the predictor by one accepted event and queue the results it causes.
    function automatic void compute_ranger_results(in_item_t ev);
        int unsigned limit;
        int unsigned next;
        logic [31:0] elapsed;
        logic [31:0] dist_cm;
        limit = sensors_in_use();
        if (ev.func == FUNC_POLL)
        begin
            if (limit == 0)
                return;
            if (m_waiting)
                awaited_results.push_back(make_result(KIND_REPORT, m_active, UNKNOWN_CM, 1'b0));
            next = m_active + 1;
            if (next >= limit)
                next = 0;
            m_active  = next[3:0];
            m_waiting = 1'b1;
            awaited_results.push_back(make_result(KIND_TRIGGER, m_active, 8'd0, 1'b1));
        end
        else if (ev.echo_level == ECHO_RISE)
        begin
            m_waiting = 1'b1;
            m_echo_t0 = ev.time_us;
        end
        else
        begin
            elapsed = ev.time_us - m_echo_t0;
            dist_cm = elapsed / (SOUND_US_PER_CM * ROUND_TRIP);
            if (dist_cm > UNKNOWN_CM)
                dist_cm = 32'(UNKNOWN_CM);
            m_waiting = 1'b0;
            awaited_results.push_back(make_result(KIND_REPORT, m_active, dist_cm[7:0], 1'b1));
        end
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp_val);
        $display("MISMATCH %s: got %0d, expected %0d (result %0d, cycle %0d)",
                 what, got, exp_val, results_checked, cycle_count);
        mismatches++;
    endtask

    // Send one event, with random idle cycles in front, and predict once it is taken.
    task automatic send_event(logic f, logic lvl, logic [31:0] t);
        in_item_t ev;
        ev.func       = f;
        ev.echo_level = lvl;
        ev.time_us    = t;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= ev;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // A poll with no sensors enabled is ignored and does not count.
        if (!(f == FUNC_POLL && sensors_in_use() == 0))
            events_accepted++;
        compute_ranger_results(ev);
    endtask

    // Stop sending, wait for every owed result, then let the block go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(logic [4:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        m_count = value;
    endtask

    task automatic set_idling(int unsigned send_idle, int unsigned recv_stall);
        idle_pct  = send_idle;
        stall_pct = recv_stall;
    endtask

    // Echo events still work with no sensors enabled; polls are ignored.
    task automatic test_no_sensors();
        send_event(FUNC_POLL, 1'b0, 32'd0);
        send_event(FUNC_ECHO, ECHO_FALL, 32'd57);
        send_event(FUNC_ECHO, ECHO_RISE, 32'hFFFF_FFF0);
        send_event(FUNC_ECHO, ECHO_FALL, 32'h0000_00C4);
        send_event(FUNC_POLL, 1'b1, 32'hFFFF_FFFF);
    endtask

    // Rotation over three sensors, with missed echoes reported as unknown.
    task automatic test_rotation();
        write_count(5'd3);
        send_event(FUNC_POLL, 1'b0, 32'd100);
        send_event(FUNC_POLL, 1'b1, 32'd200);
        send_event(FUNC_POLL, 1'b0, 32'd300);
    endtask

    // Distance rounding and saturation edges, including a wrapped timestamp.
    task automatic test_distance();
        send_event(FUNC_ECHO, ECHO_RISE, 32'd1000);
        send_event(FUNC_ECHO, ECHO_FALL, 32'd1057);
        send_event(FUNC_ECHO, ECHO_RISE, 32'd2000);
        send_event(FUNC_ECHO, ECHO_FALL, 32'd2058);
        send_event(FUNC_ECHO, ECHO_RISE, 32'd0);
        send_event(FUNC_ECHO, ECHO_FALL, 32'd11541);
        send_event(FUNC_ECHO, ECHO_FALL, 32'd11542);
        send_event(FUNC_ECHO, ECHO_FALL, 32'd11600);
        send_event(FUNC_ECHO, ECHO_RISE, 32'd5);
        send_event(FUNC_ECHO, ECHO_FALL, 32'd4);
        send_event(FUNC_ECHO, ECHO_FALL, 32'hFFFF_FFFF);
    endtask

    // Lowering the count wraps the rotation; counts above capacity are clipped.
    task automatic test_count_change();
        int i;
        write_count(5'd16);
        for (i = 0; i < 4; i++)
            send_event(FUNC_POLL, 1'b0, 32'd400 + i);
        write_count(5'd2);
        send_event(FUNC_POLL, 1'b0, 32'd500);
        write_count(5'd31);
        send_event(FUNC_POLL, 1'b1, 32'd600);
        write_count(5'd17);
        send_event(FUNC_POLL, 1'b0, 32'd700);
    endtask

    // One poll and its echo, with the echo or its falling edge lost now and then.
    task automatic measure_once();
        int unsigned sel;
        int unsigned shape;
        logic [31:0] flight;
        sel = $urandom_range(99);
        clock_us += $urandom_range(2000, 50);
        send_event(FUNC_POLL, 1'($urandom_range(1)), clock_us);
        if (sel < 8)
            return;
        clock_us += $urandom_range(600, 100);
        send_event(FUNC_ECHO, ECHO_RISE, clock_us);
        if (sel < 14)
            return;
        shape = $urandom_range(99);
        if (shape < 60)
            flight = $urandom_range(11599, 0);
        else if (shape < 80)
            flight = $urandom_range(11700, 11500);
        else if (shape < 90)
            flight = 58 * $urandom_range(200, 0) + 57 * $urandom_range(1);
        else
            flight = $urandom;
        clock_us += flight;
        send_event(FUNC_ECHO, ECHO_FALL, clock_us);
    endtask

    task automatic run_phase(logic [4:0] count, int unsigned send_idle,
                             int unsigned recv_stall, logic [31:0] start_us);
        int unsigned target;
        write_count(count);
        set_idling(send_idle, recv_stall);
        clock_us = start_us;
        target   = events_accepted + PHASE_EVENTS;
        while (events_accepted < target)
        begin
            if ($urandom_range(99) < 85)
                measure_once();
            else
                send_event(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
        end
    endtask

    task automatic test_random_traffic();
        run_phase(5'd1,  0,  0,  $urandom);
        run_phase(5'd16, 72, 0,  $urandom);
        run_phase(5'd5,  0,  72, $urandom);
        run_phase(5'd31, 17, 17, $urandom);
        run_phase(5'd0,  0,  0,  $urandom);
        run_phase(5'd2,  72, 0,  $urandom);
        run_phase(5'd17, 0,  72, $urandom);
        run_phase(5'd9,  17, 17, $urandom);
        run_phase(5'd16, 0,  0,  32'hFFFF_0000 + $urandom_range(65535));
        set_idling(0, 0);
    endtask

    // Check each transfer on the output against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
                report_mismatch("result with nothing expected", 64'(out_item), 64'd0);
            else
            begin
                want = awaited_results.pop_front();
                if (out_item.kind != want.kind)
                    report_mismatch("kind", 64'(out_item.kind), 64'(want.kind));
                if (out_item.sensor_index != want.sensor_index)
                    report_mismatch("sensor_index", 64'(out_item.sensor_index),
                                    64'(want.sensor_index));
                if (out_item.distance_cm != want.distance_cm)
                    report_mismatch("distance_cm", 64'(out_item.distance_cm),
                                    64'(want.distance_cm));
                if (out_item.last != want.last)
                    report_mismatch("last", 64'(out_item.last), 64'(want.last));
            end
            results_checked++;
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out with %0d results outstanding", awaited_results.size());
            $display("ultrasonic_round_robin_ranger regression: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_no_sensors();
        test_rotation();
        test_distance();
        test_count_change();
        test_random_traffic();
        settle();
        repeat (END_CYCLES) @(posedge clk);
        $display("Checked %0d results from %0d events over sensor counts 0 to 31,",
                 results_checked, events_accepted);
        $display("with sender gaps and receiver stalls mixed in; %0d mismatches.", mismatches);
        if (mismatches == 0)
            $display("ultrasonic_round_robin_ranger regression: pass");
        else
            $display("ultrasonic_round_robin_ranger regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/urr_pkg.sv
sv/urr_front.sv
sv/urr_queue.sv
sv/urr_back.sv
sv/ultrasonic_round_robin_ranger.sv
tb/sv/ultrasonic_round_robin_ranger_tb.sv
